>>> design/iprt_pkg.sv
// Package for the IPv4 reassembly tracker: result status codes, register map,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package iprt_pkg;

    // Result status codes
    localparam logic [2:0] ST_NOT_OURS  = 3'd0;
    localparam logic [2:0] ST_STORED    = 3'd1;
    localparam logic [2:0] ST_COMPLETE  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_MALFORMED = 3'd4;

    // Register map: register index is paddr[2]
    localparam logic REG_LOCAL_ADDR = 1'b0;

    localparam int SLOT_IDX_W = 5;   // width of the reported slot index
    localparam int KEY_W      = 48;  // source address plus identification
    localparam int COUNT_W    = 32;  // expected length plus received count

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SCAN_END,
        S_RESOLVE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;     // capture header fields
        logic clear_scan;  // reset scan pointer and search results
        logic scan;        // read next key entry
        logic resolve;     // pick slot, read its counters
        logic finish;      // update tables, load result register
    } t_cmd;

    typedef struct packed {
        logic drop;        // not for us or malformed
        logic scan_last;   // scan pointer on last slot
        logic out_free;    // result register can take a new result
    } t_stat;

endpackage

>>> design/ipv4_reassembly_tracker.sv
// IPv4 fragment reassembly tracker, top level: APB register port and
// controller/datapath pair. Depends on iprt_pkg, iprt_ctrl, iprt_dp.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one IPv4 fragment header per
//   transaction; output channel (o_valid/i_ready) returns exactly one result
//   per header, in order.
//   Headers are handled one at a time. A header for another destination or
//   with a short total length skips the key scan: the block checks it, then
//   registers its result. Any other header scans the key RAM one slot per
//   cycle over all SLOT_COUNT slots, then resolves its slot and reads the
//   slot's counters before the result is registered, so the key scan
//   dominates the handling time.
//   The result register lets the next header be accepted while a result
//   waits; if the receiver stalls, the block holds in its final step until
//   the register frees, so nothing is lost or overwritten.
//   Reset clears the local address to zero and marks every slot free; slot
//   contents need no clearing. local_address sits at byte address 0 of the
//   APB port and is to be written only while idle; the block does not enforce it.
module ipv4_reassembly_tracker #(
    parameter int SLOT_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // fragment header
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_destination_address,
    input  logic [31:0] i_source_address,
    input  logic [15:0] i_packet_ident,
    input  logic        i_more_fragments,
    input  logic [12:0] i_fragment_offset,
    input  logic [3:0]  i_header_words,
    input  logic [15:0] i_total_length,
    input  logic [7:0]  i_protocol_number,
    // result
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [iprt_pkg::SLOT_IDX_W-1:0] o_slot_index,
    output logic [15:0] o_write_offset,
    output logic [15:0] o_fragment_length,
    output logic [15:0] o_assembled_length,
    output logic [7:0]  o_protocol_out
);
    import iprt_pkg::*;

    t_cmd        cmd;
    t_stat       stat;
    logic        cfg_we;
    logic [31:0] local_addr;

    // Word-aligned decode; writes ignore the byte-lane bits, reads need them zero
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_LOCAL_ADDR);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LOCAL_ADDR && paddr[1:0] == 2'b00) ? local_addr : '0;

    iprt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (o_ready)
    );

    iprt_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .i_cfg_we              (cfg_we),
        .i_cfg_wdata           (pwdata),
        .o_local_addr          (local_addr),
        .i_destination_address (i_destination_address),
        .i_source_address      (i_source_address),
        .i_packet_ident        (i_packet_ident),
        .i_more_fragments      (i_more_fragments),
        .i_fragment_offset     (i_fragment_offset),
        .i_header_words        (i_header_words),
        .i_total_length        (i_total_length),
        .i_protocol_number     (i_protocol_number),
        .i_ready               (i_ready),
        .o_valid               (o_valid),
        .o_status              (o_status),
        .o_slot_index          (o_slot_index),
        .o_write_offset        (o_write_offset),
        .o_fragment_length     (o_fragment_length),
        .o_assembled_length    (o_assembled_length),
        .o_protocol_out        (o_protocol_out)
    );

endmodule

>>> design/iprt_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module iprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/iprt_ctrl.sv
// Controller of the reassembly tracker: sequences capture, key scan, slot
// resolution and table update. Depends on iprt_pkg.
module iprt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  iprt_pkg::t_stat i_stat,
    output iprt_pkg::t_cmd  o_cmd,
    output logic           o_ready
);
    import iprt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_stat.drop ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: n_state = S_RESOLVE;
            S_RESOLVE:  n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.load_in = i_valid;
            end
            S_CHECK:    o_cmd.clear_scan = 1'b1;
            S_SCAN:     o_cmd.scan = 1'b1;
            S_SCAN_END: o_cmd = '0;
            S_RESOLVE:  o_cmd.resolve = 1'b1;
            S_DONE:     o_cmd.finish = i_stat.out_free;
            default:    o_cmd = '0;
        endcase
    end

endmodule

>>> design/iprt_dp.sv
// Datapath of the reassembly tracker: header registers, local address register,
// key and counter RAMs, slot flags, search logic and result register.
// Depends on iprt_pkg and iprt_ram.
module iprt_dp #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  iprt_pkg::t_cmd                   i_cmd,
    output iprt_pkg::t_stat                  o_stat,
    input  logic                             i_cfg_we,
    input  logic [31:0]                      i_cfg_wdata,
    output logic [31:0]                      o_local_addr,
    input  logic [31:0]                      i_destination_address,
    input  logic [31:0]                      i_source_address,
    input  logic [15:0]                      i_packet_ident,
    input  logic                             i_more_fragments,
    input  logic [12:0]                      i_fragment_offset,
    input  logic [3:0]                       i_header_words,
    input  logic [15:0]                      i_total_length,
    input  logic [7:0]                       i_protocol_number,
    input  logic                             i_ready,
    output logic                             o_valid,
    output logic [2:0]                       o_status,
    output logic [iprt_pkg::SLOT_IDX_W-1:0]  o_slot_index,
    output logic [15:0]                      o_write_offset,
    output logic [15:0]                      o_fragment_length,
    output logic [15:0]                      o_assembled_length,
    output logic [7:0]                       o_protocol_out
);
    import iprt_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);

    // Header registers
    logic [31:0] r_dst;
    logic [31:0] r_src;
    logic [15:0] r_ident;
    logic        r_mf;
    logic [12:0] r_frag;
    logic [3:0]  r_hw;
    logic [15:0] r_total;
    logic [7:0]  r_proto;
    logic [31:0] r_local_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_dst   <= i_destination_address;
            r_src   <= i_source_address;
            r_ident <= i_packet_ident;
            r_mf    <= i_more_fragments;
            r_frag  <= i_fragment_offset;
            r_hw    <= i_header_words;
            r_total <= i_total_length;
            r_proto <= i_protocol_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= '0;
        end else if (i_cfg_we) begin
            r_local_addr <= i_cfg_wdata;
        end
    end

    assign o_local_addr = r_local_addr;

    logic [15:0] hdr_bytes;
    logic        not_ours;
    logic        malformed;
    logic [15:0] flen;
    logic [15:0] wr_off;

    assign hdr_bytes = {10'd0, r_hw, 2'b00};
    assign not_ours  = (r_dst != r_local_addr);
    assign malformed = (r_total < hdr_bytes);
    assign flen      = r_total - hdr_bytes;
    assign wr_off    = {r_frag, 3'b000};

    // Key scan, one slot per cycle; each slot is compared in the cycle after its read
    logic [IW-1:0]         r_scan_addr;
    logic                  r_cmp_en;
    logic [IW-1:0]         r_cmp_idx;
    logic                  r_found_hit;
    logic [IW-1:0]         r_found_idx;
    logic                  r_free_hit;
    logic [IW-1:0]         r_free_idx;
    logic [SLOT_COUNT-1:0] r_valid;
    logic [SLOT_COUNT-1:0] r_known;
    logic [KEY_W-1:0]      key_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_en    <= 1'b0;
            r_found_hit <= 1'b0;
            r_free_hit  <= 1'b0;
            r_scan_addr <= '0;
        end else begin
            r_cmp_en <= i_cmd.scan;
            if (i_cmd.clear_scan) begin
                r_scan_addr <= '0;
                r_found_hit <= 1'b0;
                r_free_hit  <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_scan_addr <= r_scan_addr + 1'b1;
                end
                if (r_cmp_en) begin
                    if (r_valid[r_cmp_idx]) begin
                        if (!r_found_hit && key_rdata == {r_src, r_ident}) begin
                            r_found_hit <= 1'b1;
                        end
                    end else if (!r_free_hit) begin
                        r_free_hit <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_cmp_idx <= r_scan_addr;
        end
        if (r_cmp_en && !i_cmd.clear_scan) begin
            if (r_valid[r_cmp_idx]) begin
                if (!r_found_hit && key_rdata == {r_src, r_ident}) begin
                    r_found_idx <= r_cmp_idx;
                end
            end else if (!r_free_hit) begin
                r_free_idx <= r_cmp_idx;
            end
        end
    end

    // Slot resolution
    logic [IW-1:0] sel_slot;
    logic [IW-1:0] r_slot;
    logic          r_alloc;
    logic          r_full;

    assign sel_slot = r_found_hit ? r_found_idx : r_free_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_slot  <= sel_slot;
            r_alloc <= !r_found_hit;
            r_full  <= !r_found_hit && !r_free_hit;
        end
    end

    // Counter update; a fresh slot starts from zero
    logic [COUNT_W-1:0] count_rdata;
    logic [15:0]        old_rcv;
    logic [15:0]        old_exp;
    logic               old_known;
    logic [16:0]        exp_sum;
    logic [16:0]        rcv_sum;
    logic [15:0]        new_exp;
    logic [15:0]        new_rcv;
    logic               new_known;
    logic               complete;
    logic               store_item;

    assign old_exp   = r_alloc ? 16'd0 : count_rdata[31:16];
    assign old_rcv   = r_alloc ? 16'd0 : count_rdata[15:0];
    assign old_known = r_alloc ? 1'b0 : r_known[r_slot];
    assign exp_sum   = {1'b0, wr_off} + {1'b0, flen};
    assign rcv_sum   = {1'b0, old_rcv} + {1'b0, flen};
    assign new_exp   = r_mf ? old_exp : (exp_sum[16] ? 16'hFFFF : exp_sum[15:0]);
    assign new_rcv   = rcv_sum[16] ? 16'hFFFF : rcv_sum[15:0];
    assign new_known = !r_mf || old_known;
    assign complete  = new_known && (new_rcv == new_exp);
    assign store_item = !not_ours && !malformed && !r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_known <= '0;
        end else if (i_cmd.finish && store_item) begin
            r_valid[r_slot] <= !complete;
            r_known[r_slot] <= new_known && !complete;
        end
    end

    iprt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOT_COUNT)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish && store_item && r_alloc),
        .i_waddr (r_slot),
        .i_wdata ({r_src, r_ident}),
        .i_re    (i_cmd.scan),
        .i_raddr (r_scan_addr),
        .o_rdata (key_rdata)
    );

    iprt_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (SLOT_COUNT)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish && store_item),
        .i_waddr (r_slot),
        .i_wdata ({new_exp, new_rcv}),
        .i_re    (i_cmd.resolve),
        .i_raddr (sel_slot),
        .o_rdata (count_rdata)
    );

    // Result register
    logic                  r_out_valid;
    logic [2:0]            r_out_status;
    logic [SLOT_IDX_W-1:0] r_out_slot;
    logic [15:0]           r_out_wr_off;
    logic [15:0]           r_out_flen;
    logic [15:0]           r_out_asm;
    logic [7:0]            r_out_proto;
    logic [IW+SLOT_IDX_W-1:0] slot_wide;

    assign slot_wide = {{SLOT_IDX_W{1'b0}}, r_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_proto <= r_proto;
            r_out_slot  <= '0;
            r_out_asm   <= '0;
            if (not_ours) begin
                r_out_status <= ST_NOT_OURS;
                r_out_wr_off <= '0;
                r_out_flen   <= '0;
            end else if (malformed) begin
                r_out_status <= ST_MALFORMED;
                r_out_wr_off <= wr_off;
                r_out_flen   <= '0;
            end else begin
                r_out_wr_off <= wr_off;
                r_out_flen   <= flen;
                if (r_full) begin
                    r_out_status <= ST_FULL;
                end else begin
                    r_out_slot <= slot_wide[SLOT_IDX_W-1:0];
                    if (complete) begin
                        r_out_status <= ST_COMPLETE;
                        r_out_asm    <= new_rcv;
                    end else begin
                        r_out_status <= ST_STORED;
                    end
                end
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out_status;
    assign o_slot_index       = r_out_slot;
    assign o_write_offset     = r_out_wr_off;
    assign o_fragment_length  = r_out_flen;
    assign o_assembled_length = r_out_asm;
    assign o_protocol_out     = r_out_proto;

    assign o_stat.drop      = not_ours || malformed;
    assign o_stat.scan_last = (r_scan_addr == LAST_SLOT);
    assign o_stat.out_free  = !r_out_valid || i_ready;

endmodule

>>> design/iprt_checker.sv
// Port-level checks for the reassembly tracker, bound to the top level.
// Depends on iprt_pkg and ipv4_reassembly_tracker.
module iprt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [iprt_pkg::SLOT_IDX_W-1:0] o_slot_index,
    input logic [15:0] o_fragment_length,
    input logic [15:0] o_assembled_length
);
    import iprt_pkg::*;

    // One header in flight: no acceptance in the cycle after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("header accepted on consecutive cycles");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)))
        else $error("stalled result dropped or changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= ST_MALFORMED))
        else $error("status code out of range");

    a_dropped_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_NOT_OURS || o_status == ST_MALFORMED))
            |-> (o_slot_index == '0 && o_fragment_length == '0))
        else $error("dropped header reports a slot or length");

    a_assembled_only_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_COMPLETE) |-> (o_assembled_length == '0))
        else $error("assembled length outside completion");

endmodule

bind ipv4_reassembly_tracker iprt_checker u_iprt_checker (.*);

>>> dv/tb_ipv4_reassembly_tracker.sv
// Testbench for the IPv4 reassembly tracker: drives fragment headers and APB register
// writes, predicts each result with its own copy of the slot table and checks it.
// Depends on iprt_pkg and ipv4_reassembly_tracker.
module tb_ipv4_reassembly_tracker;
    timeunit 1ns;
    timeprecision 1ps;
    import iprt_pkg::*;

    localparam int SLOTS       = 32;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 450;

    typedef struct packed {
        logic [31:0] dst;
        logic [31:0] src;
        logic [15:0] ident;
        logic        mf;
        logic [12:0] offset;
        logic [3:0]  hwords;
        logic [15:0] total;
        logic [7:0]  proto;
    } t_frag_hdr;

    typedef struct packed {
        logic [2:0]            status;
        logic [SLOT_IDX_W-1:0] slot;
        logic [15:0]           wr_off;
        logic [15:0]           frag_len;
        logic [15:0]           asm_len;
        logic [7:0]            proto;
    } t_frag_res;

    // Slot table as the block should hold it, plus the results still owed
    class t_reasm_table_model;
        logic [31:0] local_addr;
        bit          busy [SLOTS];
        bit          len_known [SLOTS];
        logic [31:0] key_src [SLOTS];
        logic [15:0] key_ident [SLOTS];
        logic [15:0] exp_len [SLOTS];
        logic [15:0] rx_len [SLOTS];
        t_frag_res   due_results [$];
        int          mismatches;

        function new();
            local_addr = '0;
            mismatches = 0;
            foreach (busy[i]) begin
                busy[i]      = 1'b0;
                len_known[i] = 1'b0;
            end
        endfunction

        function logic [15:0] sat16(int unsigned a, int unsigned b);
            return (a + b > 32'hFFFF) ? 16'hFFFF : 16'(a + b);
        endfunction

        function int live_slots();
            int n;
            n = 0;
            foreach (busy[i]) n += busy[i];
            return n;
        endfunction

        function void take_header(t_frag_hdr h);
            t_frag_res   r;
            int          hit;
            int          spare;
            int unsigned hbytes;
            r        = '0;
            r.proto  = h.proto;
            hit      = -1;
            spare    = -1;
            hbytes   = 32'(h.hwords) * 4;
            if (h.dst != local_addr) begin
                r.status = ST_NOT_OURS;
            end else if (32'(h.total) < hbytes) begin
                r.status = ST_MALFORMED;
                r.wr_off = {h.offset, 3'b000};
            end else begin
                r.frag_len = 16'(32'(h.total) - hbytes);
                r.wr_off   = {h.offset, 3'b000};
                for (int i = 0; i < SLOTS; i++) begin
                    if (busy[i]) begin
                        if (hit < 0 && key_src[i] == h.src && key_ident[i] == h.ident) hit = i;
                    end else if (spare < 0) begin
                        spare = i;
                    end
                end
                if (hit < 0 && spare >= 0) begin
                    hit            = spare;
                    busy[hit]      = 1'b1;
                    key_src[hit]   = h.src;
                    key_ident[hit] = h.ident;
                    rx_len[hit]    = '0;
                    exp_len[hit]   = '0;
                    len_known[hit] = 1'b0;
                end
                if (hit < 0) begin
                    r.status = ST_FULL;
                end else begin
                    r.slot = SLOT_IDX_W'(hit);
                    if (!h.mf) begin
                        exp_len[hit]   = sat16(r.wr_off, r.frag_len);
                        len_known[hit] = 1'b1;
                    end
                    rx_len[hit] = sat16(rx_len[hit], r.frag_len);
                    if (len_known[hit] && rx_len[hit] == exp_len[hit]) begin
                        r.status       = ST_COMPLETE;
                        r.asm_len      = rx_len[hit];
                        busy[hit]      = 1'b0;
                        len_known[hit] = 1'b0;
                    end else begin
                        r.status = ST_STORED;
                    end
                end
            end
            due_results.push_back(r);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_frag_res got);
            t_frag_res want;
            if (due_results.size() == 0) begin
                $error("status: expected no result, got %0d", got.status);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            compare("status", want.status, got.status);
            compare("slot_index", want.slot, got.slot);
            compare("write_offset", want.wr_off, got.wr_off);
            compare("fragment_length", want.frag_len, got.frag_len);
            compare("assembled_length", want.asm_len, got.asm_len);
            compare("protocol_out", want.proto, got.proto);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_valid;
    logic                  o_ready;
    logic [31:0]           i_destination_address;
    logic [31:0]           i_source_address;
    logic [15:0]           i_packet_ident;
    logic                  i_more_fragments;
    logic [12:0]           i_fragment_offset;
    logic [3:0]            i_header_words;
    logic [15:0]           i_total_length;
    logic [7:0]            i_protocol_number;
    logic                  o_valid;
    logic                  i_ready;
    logic [2:0]            o_status;
    logic [SLOT_IDX_W-1:0] o_slot_index;
    logic [15:0]           o_write_offset;
    logic [15:0]           o_fragment_length;
    logic [15:0]           o_assembled_length;
    logic [7:0]            o_protocol_out;

    t_reasm_table_model tracker = new();
    bit                 no_idle;
    int                 ours_sent;
    int                 cycles;

    ipv4_reassembly_tracker #(.SLOT_COUNT(SLOTS)) DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_destination_address(i_destination_address),
        .i_source_address     (i_source_address),
        .i_packet_ident       (i_packet_ident),
        .i_more_fragments     (i_more_fragments),
        .i_fragment_offset    (i_fragment_offset),
        .i_header_words       (i_header_words),
        .i_total_length       (i_total_length),
        .i_protocol_number    (i_protocol_number),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_status             (o_status),
        .o_slot_index         (o_slot_index),
        .o_write_offset       (o_write_offset),
        .o_fragment_length    (o_fragment_length),
        .o_assembled_length   (o_assembled_length),
        .o_protocol_out       (o_protocol_out)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_result(t_frag_res'{o_status, o_slot_index, o_write_offset,
                                             o_fragment_length, o_assembled_length,
                                             o_protocol_out});
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_frag_hdr make_header(logic [31:0] dst, logic [31:0] src,
                                              logic [15:0] ident, logic mf,
                                              logic [12:0] offset, logic [3:0] hwords,
                                              logic [15:0] total, logic [7:0] proto);
        return t_frag_hdr'{dst, src, ident, mf, offset, hwords, total, proto};
    endfunction

    function automatic t_frag_hdr noise_header();
        t_frag_hdr h;
        h = make_header($urandom, $urandom, 16'($urandom), 1'($urandom), 13'($urandom),
                        4'($urandom), 16'($urandom), 8'($urandom));
        case ($urandom_range(2))
            0: h.dst = tracker.local_addr ^ ($urandom | 32'd1);
            1: begin
                // total length shorter than the header
                h.dst    = tracker.local_addr;
                h.hwords = 4'($urandom_range(1, 15));
                h.total  = 16'($urandom_range(0, 4 * h.hwords - 1));
            end
            default: if ($urandom_range(1)) h.dst = tracker.local_addr;
        endcase
        return h;
    endfunction

    task automatic put_header(t_frag_hdr h);
        if (!no_idle && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 50);
        end
        i_valid               <= 1'b1;
        i_destination_address <= h.dst;
        i_source_address      <= h.src;
        i_packet_ident        <= h.ident;
        i_more_fragments      <= h.mf;
        i_fragment_offset     <= h.offset;
        i_header_words        <= h.hwords;
        i_total_length        <= h.total;
        i_protocol_number     <= h.proto;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (h.dst == tracker.local_addr) ours_sent++;
        tracker.take_header(h);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.due_results.size() != 0);
    endtask

    // only while idle: call drain first
    task automatic write_local_addr(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LOCAL_ADDR, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.local_addr = value;
    endtask

    // A last fragment of 65535 bytes with IHL 0 saturates both counters, so
    // every open slot completes whatever it held.
    task automatic close_open_slots();
        logic [31:0] srcs [$];
        logic [15:0] ids [$];
        foreach (tracker.busy[i]) begin
            if (tracker.busy[i]) begin
                srcs.push_back(tracker.key_src[i]);
                ids.push_back(tracker.key_ident[i]);
            end
        end
        foreach (srcs[k]) begin
            put_header(make_header(tracker.local_addr, srcs[k], ids[k], 1'b0, 13'($urandom),
                                   4'd0, 16'hFFFF, 8'($urandom)));
        end
    endtask

    task automatic fill_table();
        int extra;
        extra = SLOTS - tracker.live_slots() + $urandom_range(1, 4);
        repeat (extra) begin
            put_header(make_header(tracker.local_addr, $urandom, 16'($urandom), 1'b1,
                                   13'($urandom_range(0, 8)), 4'd5,
                                   16'(20 + 8 * $urandom_range(1, 20)), 8'($urandom)));
        end
    endtask

    // One to six fragmented packets, interleaved randomly, with up to two noise headers
    task automatic packet_burst();
        t_frag_hdr   frags [$];
        t_frag_hdr   tmp;
        int          nfrag;
        int          units;
        int          chunk;
        int          j;
        logic [31:0] src;
        logic [15:0] ident;
        logic [3:0]  hw;
        repeat ($urandom_range(1, 6)) begin
            src   = $urandom;
            ident = 16'($urandom);
            units = 0;
            nfrag = $urandom_range(1, 5);
            for (int f = 0; f < nfrag; f++) begin
                hw    = ($urandom_range(9) == 0) ? 4'($urandom_range(4))
                                                 : 4'($urandom_range(5, 15));
                chunk = (f == nfrag - 1) ? $urandom_range(0, 1480) : 8 * $urandom_range(0, 185);
                frags.push_back(make_header(tracker.local_addr, src, ident, f != nfrag - 1,
                                            13'(units), hw, 16'(4 * hw + chunk),
                                            8'($urandom)));
                units += chunk / 8;
            end
        end
        repeat ($urandom_range(0, 2)) frags.push_back(noise_header());
        for (int k = frags.size() - 1; k > 0; k--) begin
            j        = $urandom_range(k);
            tmp      = frags[k];
            frags[k] = frags[j];
            frags[j] = tmp;
        end
        foreach (frags[k]) put_header(frags[k]);
    endtask

    initial begin
        logic [31:0] a;
        logic [31:0] phase_addr [4];
        int          pick;
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        i_valid               = 1'b0;
        i_ready               = 1'b0;
        i_destination_address = '0;
        i_source_address      = '0;
        i_packet_ident        = '0;
        i_more_fragments      = 1'b0;
        i_fragment_offset     = '0;
        i_header_words        = '0;
        i_total_length        = '0;
        i_protocol_number     = '0;
        no_idle               = 1'b0;
        ours_sent             = 0;
        cycles                = 0;
        phase_addr            = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        a = $urandom;
        write_local_addr(a);
        put_header(make_header(~a, 32'h0A00_0001, 16'h0001, 1'b1, 13'd4, 4'd5, 16'd60, 8'd6));
        put_header(make_header(a, 32'h0A00_0001, 16'h0001, 1'b0, 13'd0, 4'd1, 16'd3, 8'd6));
        // unfragmented packet
        put_header(make_header(a, 32'h0A00_0001, 16'h0002, 1'b0, 13'd0, 4'd5, 16'd100, 8'd17));
        // two fragments in order, then last fragment first
        put_header(make_header(a, 32'h0A00_0002, 16'h0003, 1'b1, 13'd0, 4'd5, 16'd36, 8'd6));
        put_header(make_header(a, 32'h0A00_0002, 16'h0003, 1'b0, 13'd2, 4'd5, 16'd28, 8'd6));
        put_header(make_header(a, 32'h0A00_0002, 16'h0004, 1'b0, 13'd1, 4'd5, 16'd28, 8'd1));
        put_header(make_header(a, 32'h0A00_0002, 16'h0004, 1'b1, 13'd0, 4'd5, 16'd28, 8'd1));
        // second last fragment shortens the expected length
        put_header(make_header(a, 32'h0A00_0003, 16'h0005, 1'b0, 13'd3, 4'd5, 16'd28, 8'd2));
        put_header(make_header(a, 32'h0A00_0003, 16'h0005, 1'b0, 13'd1, 4'd5, 16'd28, 8'd2));
        // empty payload with unknown length stays open
        put_header(make_header(a, 32'h0A00_0004, 16'h0006, 1'b1, 13'd0, 4'd5, 16'd20, 8'd3));
        // IHL zero, empty last fragment
        put_header(make_header(a, 32'h0A00_0004, 16'h0007, 1'b0, 13'd0, 4'd0, 16'd0, 8'd3));
        // saturation of expected and received lengths
        put_header(make_header(a, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 13'h1FFF, 4'd15, 16'hFFFF,
                               8'hFF));
        put_header(make_header(a, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 13'd0, 4'd0, 16'hFFFF, 8'hFF));
        put_header(make_header(a, 32'h0, 16'h0, 1'b1, 13'd0, 4'd15, 16'd60, 8'h00));
        put_header(make_header(a, 32'h0, 16'h0, 1'b1, 13'd0, 4'd15, 16'd59, 8'h00));
        close_open_slots();

        for (int p = 0; p < 4; p++) begin
            drain();
            write_local_addr(phase_addr[p]);
            no_idle   = (p == 2);
            ours_sent = 0;
            while (ours_sent < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (tracker.live_slots() > 24 || pick < 4) begin
                    close_open_slots();
                end else if (pick < 8) begin
                    fill_table();
                    close_open_slots();
                end else if (pick < 11) begin
                    drain();
                end else begin
                    packet_burst();
                end
            end
            close_open_slots();
        end

        drain();
        repeat (SLOTS + 10) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
